// ===== hw/rtl/kmh_pkg.sv =====
// kmh_pkg: shared constants, codes and structs of the k-mer bottom-k sketch core
// no dependencies
`default_nettype none
package kmh_pkg;

   localparam int MAX_WINDOW   = 32;
   localparam int SKETCH_DEPTH = 1024;
   localparam int WS_W         = 6;
   localparam int KEEP_W       = 11;
   localparam int SK_AW        = $clog2(SKETCH_DEPTH);
   localparam int SK_CW        = SK_AW + 1;
   localparam int MSG_W        = 8 * MAX_WINDOW;
   localparam int CSR_W        = 11;

   localparam logic [63:0] HASH_SEED = 64'd42;
   localparam logic [63:0] MM_C1 = 64'h87c3_7b91_1142_53d5;
   localparam logic [63:0] MM_C2 = 64'h4cf5_ad43_2745_937f;
   localparam logic [63:0] MM_F1 = 64'hff51_afd7_ed55_8ccd;
   localparam logic [63:0] MM_F2 = 64'hc4ce_b9fe_1a85_ec53;
   localparam logic [63:0] MM_N1 = 64'h0000_0000_52dc_e729;
   localparam logic [63:0] MM_N2 = 64'h0000_0000_3849_5ab5;

   typedef enum logic [1:0] {
      CSR_WINDOW_SIZE = 2'd0,
      CSR_KEEP_COUNT  = 2'd1,
      CSR_SKIP_AMBIG  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_idx_type;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;
   localparam logic KIND_HASH = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic             ins;
      logic             rd;
      logic             clr;
      logic [63:0]      value;
      logic [SK_AW-1:0] idx;
   } sk_cmd_type;

   typedef struct packed {
      logic             done;
      logic [63:0]      rdata;
      logic [SK_CW-1:0] count;
   } sk_stat_type;

   typedef struct packed {
      logic full;
      logic amb;
   } win_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/kmh_if.sv =====
// kmh_req_if, kmh_rsp_if: valid/ready channels of the sketch core
// no dependencies
`default_nettype none
interface kmh_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] base;
   logic       new_sequence;
   logic [9:0] read_index;
   modport source (output valid, func, base, new_sequence, read_index, input ready);
   modport sink (input valid, func, base, new_sequence, read_index, output ready);
endinterface

interface kmh_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] hash_value;
   logic        ambiguous;
   logic [10:0] entry_count;
   logic        in_range;
   modport source (output valid, kind, hash_value, ambiguous, entry_count, in_range,
                   input ready);
   modport sink (input valid, kind, hash_value, ambiguous, entry_count, in_range,
                 output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kmh_cell.sv =====
// kmh_cell: one window position, holds a base and its non-acgt flag
// depends on nothing
`default_nettype none
module kmh_cell (
   input  wire logic       clock,
   input  wire logic       shift,
   input  wire logic [7:0] d_base,
   output logic      [7:0] q_base,
   output logic            q_odd
);
   logic [7:0] base_ff;
   logic       odd_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         base_ff <= d_base;
         odd_ff  <= !(d_base == 8'h41 || d_base == 8'h43 ||
                      d_base == 8'h47 || d_base == 8'h54);
      end
   end

   assign q_base = base_ff;
   assign q_odd  = odd_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/kmh_window.sv =====
// kmh_window: chain of window cells, fill count and message builder
// depends on kmh_pkg, kmh_cell
`default_nettype none
module kmh_window
   import kmh_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire logic            restart,
   input  wire logic [7:0]      base,
   input  wire logic [WS_W-1:0] ws,
   output win_stat_type         stat,
   output logic [MSG_W-1:0]     msg_fwd,
   output logic [MSG_W-1:0]     msg_rev
);
   logic [7:0]            cb [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] codd;
   logic [WS_W-1:0]       fill_ff, fill_in, fill_base;
   logic [MSG_W-1:0]      flipped;
   logic [WS_W-1:0]       sh;

   // cell 0 holds the newest base
   for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
      if (j == 0) begin : g_head
         kmh_cell u_cell (.clock(clock), .shift(push), .d_base(base),
                          .q_base(cb[j]), .q_odd(codd[j]));
      end else begin : g_body
         kmh_cell u_cell (.clock(clock), .shift(push), .d_base(cb[j-1]),
                          .q_base(cb[j]), .q_odd(codd[j]));
      end
   end

   always_comb begin
      fill_base = restart ? '0 : fill_ff;
      fill_in   = fill_ff;
      if (push) begin
         fill_in = (fill_base < WS_W'(MAX_WINDOW)) ? fill_base + 1'b1 : fill_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_comb begin
      stat.full = (fill_ff >= ws);
      stat.amb  = 1'b0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
         if (WS_W'(j) < ws) begin
            stat.amb = stat.amb | codd[j];
         end
         msg_rev[j*8 +: 8] = (WS_W'(j) < ws) ? cb[j] : 8'h00;
         flipped[j*8 +: 8] = cb[MAX_WINDOW-1-j];
      end
      // forward byte i is cell ws-1-i
      sh      = WS_W'(MAX_WINDOW) - ws;
      msg_fwd = flipped >> {sh, 3'b000};
   end
endmodule
`default_nettype wire

// ===== hw/rtl/kmh_murmur.sv =====
// kmh_murmur: multi-cycle first word of murmurhash3 x64 128 over one message
// depends on kmh_pkg; one shared 32x32 multiplier builds each 64-bit product from partial products
`default_nettype none
module kmh_murmur
   import kmh_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [MSG_W-1:0] msg,
   input  wire logic [WS_W-1:0]  len,
   output logic                  done,
   output logic [63:0]           hash
);
   localparam int NS = 18;

   typedef enum logic [NS-1:0] {
      M_IDLE = NS'(1) << 0,  M_K1A = NS'(1) << 1,  M_K1B = NS'(1) << 2,
      M_H1A  = NS'(1) << 3,  M_H1B = NS'(1) << 4,  M_K2A = NS'(1) << 5,
      M_K2B  = NS'(1) << 6,  M_H2A = NS'(1) << 7,  M_H2B = NS'(1) << 8,
      M_T2A  = NS'(1) << 9,  M_T2B = NS'(1) << 10, M_T1A = NS'(1) << 11,
      M_T1B  = NS'(1) << 12, M_FIN1 = NS'(1) << 13, M_FIN2 = NS'(1) << 14,
      M_FM1  = NS'(1) << 15, M_FM2 = NS'(1) << 16, M_SUM = NS'(1) << 17
   } mstate_type;

   mstate_type        st_ff, st_in;
   logic [MSG_W-1:0]  msg_ff;
   logic [WS_W-1:0]   len_ff;
   logic [63:0]       h1_ff, h2_ff, k1_ff, k2_ff;
   logic [1:0]        blk_ff;
   logic              fsel_ff;
   logic [1:0]        mcnt_ff;
   logic [63:0]       p0_ff;
   logic [31:0]       cross_ff;
   logic              done_ff;
   logic [63:0]       ma, mb, fx, r, fr, len64;
   logic [31:0]       mop_a, mop_b;
   logic [63:0]       prod;
   logic              is_mul, mul_done;
   logic [1:0]        nb, blk_n;

   function automatic logic [63:0] word_at(input logic [MSG_W-1:0] m, input logic [2:0] w);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < MSG_W / 64; i++) begin
         if (w == 3'(i)) v = m[i*64 +: 64];
      end
      return v;
   endfunction

   function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
      return (x << n) | (x >> (64 - n));
   endfunction

   assign nb    = len[5:4];
   assign blk_n = blk_ff + 2'd1;
   assign len64 = {58'd0, len_ff};
   assign fx    = fsel_ff ? (h2_ff ^ (h2_ff >> 33)) : (h1_ff ^ (h1_ff >> 33));

   always_comb begin
      is_mul = st_ff inside {M_K1A, M_K1B, M_K2A, M_K2B, M_T2A, M_T2B, M_T1A, M_T1B,
                             M_FM1, M_FM2};
      ma = k1_ff;
      mb = MM_C1;
      case (st_ff)
         M_K1A, M_T1A: begin ma = k1_ff; mb = MM_C1; end
         M_K1B, M_T1B: begin ma = k1_ff; mb = MM_C2; end
         M_K2A, M_T2A: begin ma = k2_ff; mb = MM_C2; end
         M_K2B, M_T2B: begin ma = k2_ff; mb = MM_C1; end
         M_FM1:        begin ma = fx;    mb = MM_F1; end
         M_FM2:        begin ma = fx;    mb = MM_F2; end
         default:      begin ma = k1_ff; mb = MM_C1; end
      endcase
      // partial products: lo*lo, lo*hi, hi*lo
      mop_a    = (mcnt_ff == 2'd2) ? ma[63:32] : ma[31:0];
      mop_b    = (mcnt_ff == 2'd1) ? mb[63:32] : mb[31:0];
      prod     = mop_a * mop_b;
      r        = p0_ff + {cross_ff, 32'd0};
      fr       = r ^ (r >> 33);
      mul_done = is_mul && (mcnt_ff == 2'd3);
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         M_IDLE:  if (start) st_in = (len[5:4] != 2'd0) ? M_K1A : M_T2A;
         M_K1A:   if (mul_done) st_in = M_K1B;
         M_K1B:   if (mul_done) st_in = M_H1A;
         M_H1A:   st_in = M_H1B;
         M_H1B:   st_in = M_K2A;
         M_K2A:   if (mul_done) st_in = M_K2B;
         M_K2B:   if (mul_done) st_in = M_H2A;
         M_H2A:   st_in = M_H2B;
         M_H2B:   st_in = (blk_n < len_ff[5:4]) ? M_K1A : M_T2A;
         M_T2A:   if (mul_done) st_in = M_T2B;
         M_T2B:   if (mul_done) st_in = M_T1A;
         M_T1A:   if (mul_done) st_in = M_T1B;
         M_T1B:   if (mul_done) st_in = M_FIN1;
         M_FIN1:  st_in = M_FIN2;
         M_FIN2:  st_in = M_FM1;
         M_FM1:   if (mul_done) st_in = M_FM2;
         M_FM2:   if (mul_done) st_in = fsel_ff ? M_SUM : M_FM1;
         M_SUM:   st_in = M_IDLE;
         default: st_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= M_IDLE;
         mcnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         mcnt_ff <= is_mul ? mcnt_ff + 2'd1 : 2'd0;
         done_ff <= (st_ff == M_SUM);
      end
   end

   always_ff @(posedge clock) begin
      case (mcnt_ff)
         2'd0:    p0_ff    <= prod;
         2'd1:    cross_ff <= prod[31:0];
         2'd2:    cross_ff <= cross_ff + prod[31:0];
         default: cross_ff <= cross_ff;
      endcase
      case (st_ff)
         M_IDLE: begin
            if (start) begin
               msg_ff  <= msg;
               len_ff  <= len;
               h1_ff   <= HASH_SEED;
               h2_ff   <= HASH_SEED;
               blk_ff  <= '0;
               fsel_ff <= 1'b0;
               k1_ff   <= word_at(msg, {nb, 1'b0});
               k2_ff   <= word_at(msg, {nb, 1'b1});
               if (nb != 2'd0) begin
                  k1_ff <= word_at(msg, 3'd0);
                  k2_ff <= word_at(msg, 3'd1);
               end
            end
         end
         M_K1A, M_T1A: if (mul_done) k1_ff <= rotl(r, 31);
         M_K1B, M_T1B: if (mul_done) h1_ff <= h1_ff ^ r;
         M_K2A, M_T2A: if (mul_done) k2_ff <= rotl(r, 33);
         M_K2B, M_T2B: if (mul_done) h2_ff <= h2_ff ^ r;
         M_H1A: h1_ff <= rotl(h1_ff, 27) + h2_ff;
         M_H1B: h1_ff <= h1_ff + (h1_ff << 2) + MM_N1;
         M_H2A: h2_ff <= rotl(h2_ff, 31) + h1_ff;
         M_H2B: begin
            h2_ff  <= h2_ff + (h2_ff << 2) + MM_N2;
            blk_ff <= blk_n;
            k1_ff  <= word_at(msg_ff, {blk_n, 1'b0});
            k2_ff  <= word_at(msg_ff, {blk_n, 1'b1});
         end
         M_FIN1: begin
            h1_ff <= (h1_ff ^ len64) + (h2_ff ^ len64);
            h2_ff <= h2_ff ^ len64;
         end
         M_FIN2: h2_ff <= h2_ff + h1_ff;
         M_FM1: begin
            if (mul_done) begin
               if (fsel_ff) h2_ff <= r;
               else         h1_ff <= r;
            end
         end
         M_FM2: begin
            if (mul_done) begin
               if (fsel_ff) h2_ff <= fr;
               else         h1_ff <= fr;
               fsel_ff <= 1'b1;
            end
         end
         M_SUM:   h1_ff <= h1_ff + h2_ff;
         default: h1_ff <= h1_ff;
      endcase
   end

   assign done = done_ff;
   assign hash = h1_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/kmh_sketch.sv =====
// kmh_sketch: sorted bottom-k store in a single-port memory, shift insertion
// depends on kmh_pkg
`default_nettype none
module kmh_sketch
   import kmh_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [KEEP_W-1:0] keep,
   input  wire sk_cmd_type        cmd,
   output sk_stat_type            stat
);
   typedef enum logic [4:0] {
      K_IDLE = 5'b00001,
      K_FULL = 5'b00010,
      K_SRD  = 5'b00100,
      K_SCMP = 5'b01000,
      K_RDW  = 5'b10000
   } kstate_type;

   logic [63:0]      mem [SKETCH_DEPTH];
   kstate_type       st_ff, st_in;
   logic [SK_CW-1:0] count_ff, count_in, cap, cnt_t;
   logic [SK_AW-1:0] pos_ff, pos_in;
   logic [63:0]      val_ff, rdata_ff;
   logic             done_ff, done_in;
   logic             we, re;
   logic [SK_AW-1:0] waddr, raddr;
   logic [63:0]      wdata;

   always_comb begin
      cap = keep;
      if (keep == '0) cap = SK_CW'(1);
      if (keep > SK_CW'(SKETCH_DEPTH)) cap = SK_CW'(SKETCH_DEPTH);
      cnt_t = (count_ff > cap) ? cap : count_ff;
   end

   always_comb begin
      st_in    = st_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      done_in  = 1'b0;
      we       = 1'b0;
      re       = 1'b0;
      waddr    = pos_ff;
      raddr    = pos_ff;
      wdata    = val_ff;
      case (st_ff)
         K_IDLE: begin
            if (cmd.clr) count_in = '0;
            if (cmd.rd) begin
               re    = 1'b1;
               raddr = cmd.idx;
               st_in = K_RDW;
            end else if (cmd.ins) begin
               if (cnt_t < cap) begin
                  pos_in   = cnt_t[SK_AW-1:0];
                  count_in = cnt_t + 1'b1;
                  st_in    = K_SRD;
               end else begin
                  count_in = cap;
                  re       = 1'b1;
                  raddr    = SK_AW'(cap - 1'b1);
                  st_in    = K_FULL;
               end
            end
         end
         K_FULL: begin
            if (val_ff < rdata_ff) begin
               pos_in = SK_AW'(cap - 1'b1);
               st_in  = K_SRD;
            end else begin
               done_in = 1'b1;
               st_in   = K_IDLE;
            end
         end
         K_SRD: begin
            if (pos_ff == '0) begin
               we      = 1'b1;
               done_in = 1'b1;
               st_in   = K_IDLE;
            end else begin
               re    = 1'b1;
               raddr = pos_ff - 1'b1;
               st_in = K_SCMP;
            end
         end
         K_SCMP: begin
            we = 1'b1;
            if (rdata_ff > val_ff) begin
               wdata  = rdata_ff;
               pos_in = pos_ff - 1'b1;
               st_in  = K_SRD;
            end else begin
               done_in = 1'b1;
               st_in   = K_IDLE;
            end
         end
         K_RDW: begin
            done_in = 1'b1;
            st_in   = K_IDLE;
         end
         default: st_in = K_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= K_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (st_ff == K_IDLE && cmd.ins) val_ff <= cmd.value;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign stat.done  = done_ff;
   assign stat.rdata = rdata_ff;
   assign stat.count = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SK_CW'(SKETCH_DEPTH)) else $error("sketch count above depth");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("sketch done longer than one cycle");
   a_no_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != K_IDLE) |-> !(cmd.ins || cmd.rd)) else $error("sketch command while busy");
endmodule
`default_nettype wire

// ===== hw/rtl/kmer_minhash_bottom_k_sketch_core.sv =====
// kmer_minhash_bottom_k_sketch_core: top level, k-mer window, two hash units, sketch store
// depends on kmh_pkg, kmh_if, kmh_window, kmh_murmur, kmh_sketch
//
//   channel   direction  handshake          contents
//   req_chan  in         valid/ready        func, base, new_sequence, read_index
//   rsp_chan  out        valid/ready        kind, hash_value, ambiguous, entry_count, in_range
//   csr_*     in         write enable only  index 0 window_size, 1 keep_count, 2 skip_ambiguous
//
// one item at a time; a push that completes a window is hashed in both murmur units
//   (unless skipping zeroes it), then sorted into the store, larger entries shifting up
//   one place at a time through the single sketch memory port
// a push that does not fill the window gives no result; a readout reads one store entry
// reset is synchronous: control, fill count and entry count clear, store and window do not
// a finished result sits in the output register, so the next item is taken while it waits
`default_nettype none
module kmer_minhash_bottom_k_sketch_core
   import kmh_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   kmh_req_if.sink               req_chan,
   kmh_rsp_if.source             rsp_chan,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_CHK  = 6'b000010,
      S_HASH = 6'b000100,
      S_INS  = 6'b001000,
      S_READ = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   state_type           st_ff, st_in;
   logic [WS_W-1:0]     ws_ff;
   logic [KEEP_W-1:0]   keep_ff;
   logic                skip_ff;
   logic [WS_W-1:0]     ws_eff;
   logic                accept, do_push, do_read;
   win_stat_type        wstat;
   logic [MSG_W-1:0]    msg_fwd, msg_rev;
   logic                mm_start, fwd_done, rev_done;
   logic [63:0]         fwd_h, rev_h, fwd_s, rev_s, hmin;
   sk_cmd_type          skc;
   sk_stat_type         sks;
   // result staged before the output register
   logic                kind_ff, amb_ff, inr_ff;
   logic [63:0]         hash_ff;
   // output register
   logic                rv_ff;
   logic                rkind_ff, ramb_ff, rinr_ff;
   logic [63:0]         rhash_ff;
   logic [SK_CW-1:0]    rcount_ff;
   logic                emit;
   logic                zero_hash;

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff   <= WS_W'(16);
         keep_ff <= KEEP_W'(1000);
         skip_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_WINDOW_SIZE: ws_ff   <= csr_wdata[WS_W-1:0];
            CSR_KEEP_COUNT:  keep_ff <= csr_wdata[KEEP_W-1:0];
            CSR_SKIP_AMBIG:  skip_ff <= csr_wdata[0];
            default:         ws_ff   <= ws_ff;
         endcase
      end
   end

   // window size clamped to 1..MAX_WINDOW
   always_comb begin
      ws_eff = ws_ff;
      if (ws_ff == '0) ws_eff = WS_W'(1);
      if (ws_ff > WS_W'(MAX_WINDOW)) ws_eff = WS_W'(MAX_WINDOW);
   end

   // ---- input side
   assign req_chan.ready = (st_ff == S_IDLE);
   assign accept  = req_chan.valid && req_chan.ready;
   assign do_push = accept && (req_chan.func == FUNC_PUSH);
   assign do_read = accept && (req_chan.func == FUNC_READ);

   kmh_window u_window (
      .clock   (clock),
      .reset   (reset),
      .push    (do_push),
      .restart (req_chan.new_sequence),
      .base    (req_chan.base),
      .ws      (ws_eff),
      .stat    (wstat),
      .msg_fwd (msg_fwd),
      .msg_rev (msg_rev)
   );

   // window with a non-acgt base and skipping on gives zero without hashing
   assign zero_hash = skip_ff && wstat.amb;
   assign mm_start  = (st_ff == S_CHK) && wstat.full && !zero_hash;

   kmh_murmur u_mm_fwd (
      .clock (clock), .reset (reset), .start (mm_start), .msg (msg_fwd),
      .len (ws_eff), .done (fwd_done), .hash (fwd_h)
   );

   kmh_murmur u_mm_rev (
      .clock (clock), .reset (reset), .start (mm_start), .msg (msg_rev),
      .len (ws_eff), .done (rev_done), .hash (rev_h)
   );

   // halves swapped, then the smaller of the two strands
   assign fwd_s = {fwd_h[31:0], fwd_h[63:32]};
   assign rev_s = {rev_h[31:0], rev_h[63:32]};
   assign hmin  = (fwd_s < rev_s) ? fwd_s : rev_s;

   always_comb begin
      skc.clr   = do_push && req_chan.new_sequence;
      skc.rd    = do_read;
      skc.idx   = req_chan.read_index;
      skc.ins   = ((st_ff == S_CHK) && wstat.full && zero_hash) ||
                  ((st_ff == S_HASH) && fwd_done);
      skc.value = (st_ff == S_HASH) ? hmin : 64'd0;
   end

   kmh_sketch u_sketch (
      .clock (clock),
      .reset (reset),
      .keep  (keep_ff),
      .cmd   (skc),
      .stat  (sks)
   );

   // ---- sequencing
   assign emit = (st_ff == S_EMIT) && (!rv_ff || rsp_chan.ready);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: begin
            if (do_push) st_in = S_CHK;
            else if (do_read) st_in = S_READ;
         end
         S_CHK: begin
            if (!wstat.full) st_in = S_IDLE;
            else if (zero_hash) st_in = S_INS;
            else st_in = S_HASH;
         end
         S_HASH:  if (fwd_done) st_in = S_INS;
         S_INS:   if (sks.done) st_in = S_EMIT;
         S_READ:  if (sks.done) st_in = S_EMIT;
         S_EMIT:  if (emit) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // staged result fields
   always_ff @(posedge clock) begin
      if (do_read) begin
         kind_ff <= KIND_READ;
         amb_ff  <= 1'b0;
         inr_ff  <= ({1'b0, req_chan.read_index} < sks.count);
      end
      if (st_ff == S_CHK) begin
         kind_ff <= KIND_HASH;
         amb_ff  <= zero_hash;
         inr_ff  <= 1'b0;
         hash_ff <= 64'd0;
      end
      if (st_ff == S_HASH && fwd_done) hash_ff <= hmin;
      if (st_ff == S_READ && sks.done) hash_ff <= inr_ff ? sks.rdata : 64'd0;
   end

   // ---- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (emit) begin
         rv_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rkind_ff  <= kind_ff;
         rhash_ff  <= hash_ff;
         ramb_ff   <= amb_ff;
         rcount_ff <= sks.count;
         rinr_ff   <= inr_ff;
      end
   end

   assign rsp_chan.valid       = rv_ff;
   assign rsp_chan.kind        = rkind_ff;
   assign rsp_chan.hash_value  = rhash_ff;
   assign rsp_chan.ambiguous   = ramb_ff;
   assign rsp_chan.entry_count = rcount_ff;
   assign rsp_chan.in_range    = rinr_ff;

   a_strands_together: assert property (@(posedge clock) disable iff (reset)
      fwd_done == rev_done) else $error("hash units out of step");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mm_start |=> (st_ff == S_HASH)) else $error("hash start outside check");
   a_hash_wait: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_HASH) |-> !accept) else $error("item taken while hashing");
endmodule
`default_nettype wire

// ===== dv/kmer_minhash_bottom_k_sketch_core_tb.sv =====
// kmer_minhash_bottom_k_sketch_core_tb: self-checking bench for the k-mer bottom-k sketch core
// depends on kmh_pkg, kmh_if and the core; holds its own murmur and sorted-store predictor
`default_nettype none
module kmer_minhash_bottom_k_sketch_core_tb;
   import kmh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CH_A = "A";
   localparam logic [7:0] CH_C = "C";
   localparam logic [7:0] CH_G = "G";
   localparam logic [7:0] CH_T = "T";
   localparam logic [7:0] CH_N = "N";
   localparam logic [7:0] CH_LOW_A = "a";
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic        kind;
      logic [63:0] hash_value;
      logic        ambiguous;
      logic [10:0] entry_count;
      logic        in_range;
   } sketch_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   kmh_req_if req_chan();
   kmh_rsp_if rsp_chan();

   kmer_minhash_bottom_k_sketch_core dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor copy of registers and state
   logic [5:0]  win_len_reg;
   logic [10:0] keep_reg;
   logic        skip_reg;
   logic [7:0]  win_bytes [MAX_WINDOW];
   int          win_fill;
   logic [63:0] sketch_mem [SKETCH_DEPTH];
   int          sketch_cnt;

   sketch_result_type pending_results[$];
   int  error_count = 0;
   bit  sender_bursty = 0;
   int  burst_left = 0;
   bit  receiver_stalls = 0;
   int  hold_off_cycles = 0;
   logic [15:0] stall_pattern = 16'h0;
   int  stall_pos = 0;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------- murmur model ----------------
   function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic logic [63:0] fmix(input logic [63:0] k);
      k ^= k >> 33;
      k *= MM_F1;
      k ^= k >> 33;
      k *= MM_F2;
      k ^= k >> 33;
      return k;
   endfunction

   function automatic logic [63:0] bytes_le(input logic [7:0] msg [MAX_WINDOW],
                                            input int first, input int n);
      logic [63:0] v;
      v = 64'd0;
      for (int i = 0; i < n; i++) v |= 64'(msg[first + i]) << (8 * i);
      return v;
   endfunction

   // first word of the 128-bit murmur digest, seed 42
   function automatic logic [63:0] murmur_word(input logic [7:0] msg [MAX_WINDOW],
                                               input int len);
      logic [63:0] h1, h2, k1, k2;
      int blocks, rest, tail;
      h1 = HASH_SEED;
      h2 = HASH_SEED;
      blocks = len / 16;
      for (int i = 0; i < blocks; i++) begin
         k1 = bytes_le(msg, 16 * i, 8);
         k2 = bytes_le(msg, 16 * i + 8, 8);
         k1 *= MM_C1; k1 = rotl(k1, 31); k1 *= MM_C2; h1 ^= k1;
         h1 = rotl(h1, 27); h1 += h2; h1 = h1 * 64'd5 + MM_N1;
         k2 *= MM_C2; k2 = rotl(k2, 33); k2 *= MM_C1; h2 ^= k2;
         h2 = rotl(h2, 31); h2 += h1; h2 = h2 * 64'd5 + MM_N2;
      end
      tail = 16 * blocks;
      rest = len & 15;
      if (rest > 8) begin
         k2 = bytes_le(msg, tail + 8, rest - 8);
         k2 *= MM_C2; k2 = rotl(k2, 33); k2 *= MM_C1; h2 ^= k2;
      end
      if (rest > 0) begin
         k1 = bytes_le(msg, tail, (rest > 8) ? 8 : rest);
         k1 *= MM_C1; k1 = rotl(k1, 31); k1 *= MM_C2; h1 ^= k1;
      end
      h1 ^= 64'(len);
      h2 ^= 64'(len);
      h1 += h2;
      h2 += h1;
      h1 = fmix(h1);
      h2 = fmix(h2);
      return h1 + h2;
   endfunction

   // ---------------- sorted store model ----------------
   function automatic void sketch_insert(input logic [63:0] v);
      int cap, pos;
      cap = (keep_reg == 0) ? 1 : ((keep_reg > SKETCH_DEPTH) ? SKETCH_DEPTH : int'(keep_reg));
      // lowered keep count trims the largest entries first
      if (sketch_cnt > cap) sketch_cnt = cap;
      if (sketch_cnt < cap) begin
         pos = sketch_cnt;
         sketch_cnt++;
      end else begin
         if (!(v < sketch_mem[cap - 1])) return;
         pos = cap - 1;
      end
      while (pos > 0 && sketch_mem[pos - 1] > v) begin
         sketch_mem[pos] = sketch_mem[pos - 1];
         pos--;
      end
      sketch_mem[pos] = v;
   endfunction

   // expected result appended at the tail of the queue
   function automatic void queue_result(input sketch_result_type r);
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic void predict_item(input logic f, input logic [7:0] b,
                                        input logic ns, input logic [9:0] ri);
      sketch_result_type r;
      logic [7:0] fwd [MAX_WINDOW];
      logic [7:0] rev [MAX_WINDOW];
      logic [63:0] hf, hr, h;
      logic amb;
      int wl;
      if (f == FUNC_READ) begin
         r.kind = KIND_READ;
         r.in_range = (int'(ri) < sketch_cnt);
         r.hash_value = r.in_range ? sketch_mem[ri] : 64'd0;
         r.ambiguous = 1'b0;
         r.entry_count = 11'(sketch_cnt);
         queue_result(r);
         return;
      end
      if (ns) begin
         win_fill = 0;
         sketch_cnt = 0;
      end
      for (int i = 0; i < MAX_WINDOW - 1; i++) win_bytes[i] = win_bytes[i + 1];
      win_bytes[MAX_WINDOW - 1] = b;
      if (win_fill < MAX_WINDOW) win_fill++;
      wl = (win_len_reg == 0) ? 1 : ((win_len_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_len_reg));
      if (win_fill < wl) return;   // window not yet full, nothing comes back
      amb = 1'b0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         fwd[i] = 8'd0;
         rev[i] = 8'd0;
      end
      for (int i = 0; i < wl; i++) begin
         fwd[i] = win_bytes[MAX_WINDOW - wl + i];
         rev[wl - 1 - i] = fwd[i];
         if (!(fwd[i] == CH_A || fwd[i] == CH_C || fwd[i] == CH_G || fwd[i] == CH_T))
            amb = 1'b1;
      end
      if (skip_reg && amb) begin
         h = 64'd0;
      end else begin
         amb = 1'b0;
         hf = murmur_word(fwd, wl);
         hr = murmur_word(rev, wl);
         hf = {hf[31:0], hf[63:32]};
         hr = {hr[31:0], hr[63:32]};
         h = (hf < hr) ? hf : hr;
      end
      sketch_insert(h);
      r.kind = KIND_HASH;
      r.hash_value = h;
      r.ambiguous = amb;
      r.entry_count = 11'(sketch_cnt);
      r.in_range = 1'b0;
      queue_result(r);
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      sketch_result_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, hash %h", $time, rsp_chan.hash_value);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_chan.kind !== e.kind) begin
               $display("%0t: kind exp %0d got %0d", $time, e.kind, rsp_chan.kind);
               error_count++;
            end
            if (rsp_chan.hash_value !== e.hash_value) begin
               $display("%0t: hash_value exp %h got %h", $time, e.hash_value,
                        rsp_chan.hash_value);
               error_count++;
            end
            if (rsp_chan.ambiguous !== e.ambiguous) begin
               $display("%0t: ambiguous exp %0d got %0d", $time, e.ambiguous,
                        rsp_chan.ambiguous);
               error_count++;
            end
            if (rsp_chan.entry_count !== e.entry_count) begin
               $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                        rsp_chan.entry_count);
               error_count++;
            end
            if (rsp_chan.in_range !== e.in_range) begin
               $display("%0t: in_range exp %0d got %0d", $time, e.in_range,
                        rsp_chan.in_range);
               error_count++;
            end
         end
      end
   end

   // receiver: long hold-off when asked, else a rolling stall pattern or always ready
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_off_cycles--;
      end else if (!receiver_stalls) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= stall_pattern[stall_pos];
         stall_pos++;
         if (stall_pos == 16) begin
            stall_pos = 0;
            stall_pattern = 16'($urandom) | 16'($urandom);   // mostly ready
         end
      end
   end

   // ---------------- stimulus helpers ----------------
   task automatic send_item(input logic f, input logic [7:0] b, input logic ns,
                            input logic [9:0] ri);
      int gap;
      @(negedge clock);
      if (sender_bursty) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= f;
      req_chan.base <= b;
      req_chan.new_sequence <= ns;
      req_chan.read_index <= ri;
      do @(posedge clock); while (!req_chan.ready);
      predict_item(f, b, ns, ri);
   endtask

   task automatic push_base(input logic [7:0] b, input logic ns);
      send_item(FUNC_PUSH, b, ns, 10'($urandom));
   endtask

   task automatic read_entry(input logic [9:0] ri, input logic ns);
      send_item(FUNC_READ, 8'($urandom), ns, ri);
   endtask

   // all results in, then slack for a push that gives none
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WINDOW_SIZE: win_len_reg = 6'(value);
         CSR_KEEP_COUNT:  keep_reg = 11'(value);
         CSR_SKIP_AMBIG:  skip_reg = 1'(value);
         default: ;
      endcase
   endtask

   task automatic configure(input int wl, input int keep, input int skip);
      wait_idle();
      write_reg(CSR_WINDOW_SIZE, wl);
      write_reg(CSR_KEEP_COUNT, keep);
      write_reg(CSR_SKIP_AMBIG, skip);
   endtask

   function automatic logic [7:0] random_acgt();
      case ($urandom_range(0, 3))
         0: return CH_A;
         1: return CH_C;
         2: return CH_G;
         default: return CH_T;
      endcase
   endfunction

   // ---------------- tests ----------------
   task automatic test_extremes();
      // single-base windows, one-entry store, raw bytes hashed
      configure(1, 1, 0);
      push_base(8'h00, 1'b1);
      push_base(8'hFF, 1'b0);
      push_base(CH_A, 1'b0);
      read_entry(10'd0, 1'b1);          // new_sequence ignored on a readout
      read_entry(10'd1023, 1'b0);       // out of range
      // zero window and zero keep count clamp to one
      configure(0, 0, 1);
      push_base(CH_N, 1'b1);            // ambiguous gives zero
      push_base(CH_LOW_A, 1'b0);        // lowercase is ambiguous
      push_base(CH_G, 1'b0);
      read_entry(10'd0, 1'b0);
      // oversize registers clamp to the largest window and store
      configure(63, 2047, 1);
      for (int i = 0; i < 34; i++) push_base((i == 33) ? CH_N : random_acgt(), i == 0);
      read_entry(10'd2, 1'b0);
      // largest exact window with skipping off and non-ACGT content
      configure(32, 1024, 0);
      for (int i = 0; i < 33; i++) push_base((i % 7 == 3) ? CH_N : random_acgt(), i == 0);
      // keep count lowered below what is held
      configure(3, 8, 1);
      for (int i = 0; i < 12; i++) push_base(random_acgt(), i == 0);
      configure(3, 2, 1);
      push_base(random_acgt(), 1'b0);
      read_entry(10'd0, 1'b0);
      read_entry(10'd1, 1'b0);
      read_entry(10'd2, 1'b0);
   endtask

   task automatic random_phase(input int items);
      logic [7:0] b;
      logic ns;
      int pick;
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            // mostly near the held count, sometimes anywhere
            if ($urandom_range(0, 3) == 0) read_entry(10'($urandom), 1'($urandom));
            else read_entry(10'($urandom_range(0, sketch_cnt + 2)), 1'($urandom));
         end else begin
            b = (pick < 22) ? 8'($urandom) : ((pick < 25) ? CH_N : random_acgt());
            ns = ($urandom_range(0, 60) == 0);
            push_base(b, ns);
         end
      end
   endtask

   task automatic test_random_settings();
      int wl, keep;
      for (int p = 0; p < 12; p++) begin
         sender_bursty = (p % 3 != 2);
         receiver_stalls = (p % 4 != 1);
         wl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 12);
         keep = ($urandom_range(0, 7) == 0) ? $urandom_range(900, 1024)
                                            : $urandom_range(1, 40);
         configure(wl, keep, $urandom_range(0, 1));
         push_base(random_acgt(), 1'b1);
         random_phase(60);
      end
   endtask

   task automatic test_back_pressure();
      configure(4, 16, 1);
      sender_bursty = 0;
      receiver_stalls = 0;
      hold_off_cycles = 400;
      for (int i = 0; i < 30; i++) push_base(random_acgt(), i == 0);
      wait (hold_off_cycles == 0);
      // pause until every result is back, then carry on
      wait_idle();
      receiver_stalls = 1;
      random_phase(40);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_WINDOW_SIZE;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_PUSH;
      req_chan.base = 8'd0;
      req_chan.new_sequence = 1'b0;
      req_chan.read_index = 10'd0;
      rsp_chan.ready = 1'b1;
      win_len_reg = 6'd16;
      keep_reg = 11'd1000;
      skip_reg = 1'b1;
      win_fill = 0;
      sketch_cnt = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_random_settings();
      test_back_pressure();
      wait_idle();

      if (error_count == 0) $display("kmer_minhash_bottom_k_sketch_core_tb OK");
      else $display("kmer_minhash_bottom_k_sketch_core_tb NOT OK");
      $finish;
   end

   initial begin
      #60ms;
      $display("kmer_minhash_bottom_k_sketch_core_tb NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
